### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the biquad cascade RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk_i edge, masked while rst_ni is low.
`define IBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition never holds.
`define IBC_ASSERT_NEVER(lbl, cond, msg) \
  `IBC_ASSERT(lbl, !(cond), msg)

`endif

### src/ibc_pkg.sv
// ----------------------------------------------------------------------------
// ibc_pkg
// Types, constants and the microprogram of the biquad cascade.
// ----------------------------------------------------------------------------
`default_nettype none

package ibc_pkg;

  localparam int unsigned SECTIONS_DEF  = 11;
  localparam int unsigned COEFS_PER_SEC = 5;
  localparam int unsigned FRAC_BITS     = 11;
  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned COEF_W        = 21;
  localparam int unsigned ACC_W         = 32;
  localparam int unsigned SEC_FIELD_W   = 4;
  localparam int unsigned IDX_FIELD_W   = 3;
  localparam int unsigned LIN_W         = 8;   // section*5+index of a write
  localparam int unsigned UPC_W         = 3;

  localparam logic ACTION_SAMPLE = 1'b0;
  localparam logic ACTION_COEF   = 1'b1;

  // Coefficient selectors, also the offset within a section's row.
  localparam logic [IDX_FIELD_W-1:0] K_B0 = 3'd0;
  localparam logic [IDX_FIELD_W-1:0] K_B1 = 3'd1;
  localparam logic [IDX_FIELD_W-1:0] K_B2 = 3'd2;
  localparam logic [IDX_FIELD_W-1:0] K_A1 = 3'd3;
  localparam logic [IDX_FIELD_W-1:0] K_A2 = 3'd4;

  typedef enum logic [1:0] {
    MUL_W1,
    MUL_W2,
    MUL_W
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_NOP,
    ACC_SUB,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } seq_state_e;

  typedef struct packed {
    logic                   rd_en;     // issue a coefficient read
    logic [IDX_FIELD_W-1:0] rd_k;      // which coefficient of the section
    logic                   latch_w;   // capture w1, w2 of the section
    logic                   mul_en;    // register a product
    mul_sel_e               mul_sel;   // data operand of the product
    acc_op_e                acc_op;    // accumulator update
    logic                   wr_delay;  // shift the section's delays
    logic                   sec_end;   // last step of a section
  } ucode_t;

  typedef struct packed {
    ucode_t uw;
    logic   idle;
    logic   load_out;
  } ctrl_t;

  localparam ucode_t UCODE_NOP = '{
    rd_en: 1'b0, rd_k: K_B0, latch_w: 1'b0, mul_en: 1'b0, mul_sel: MUL_W1,
    acc_op: ACC_NOP, wr_delay: 1'b0, sec_end: 1'b0
  };

  // One section in eight steps; coefficient data arrives in the step after
  // its read, a product lands in the accumulator in the step after it is taken.
  function automatic ucode_t ucode(input logic [UPC_W-1:0] upc);
    ucode_t uw;
    uw = UCODE_NOP;
    unique case (upc)
      3'd0: begin
        uw.rd_en   = 1'b1;  uw.rd_k = K_A1;
        uw.latch_w = 1'b1;
      end
      3'd1: begin
        uw.rd_en  = 1'b1;  uw.rd_k = K_A2;
        uw.mul_en = 1'b1;  uw.mul_sel = MUL_W1;
      end
      3'd2: begin
        uw.mul_en = 1'b1;  uw.mul_sel = MUL_W2;
        uw.acc_op = ACC_SUB;
      end
      3'd3: begin
        uw.rd_en  = 1'b1;  uw.rd_k = K_B0;
        uw.acc_op = ACC_SUB;
      end
      3'd4: begin
        uw.rd_en    = 1'b1;  uw.rd_k = K_B1;
        uw.mul_en   = 1'b1;  uw.mul_sel = MUL_W;
        uw.wr_delay = 1'b1;
      end
      3'd5: begin
        uw.rd_en  = 1'b1;  uw.rd_k = K_B2;
        uw.mul_en = 1'b1;  uw.mul_sel = MUL_W1;
        uw.acc_op = ACC_LOAD;
      end
      3'd6: begin
        uw.mul_en = 1'b1;  uw.mul_sel = MUL_W2;
        uw.acc_op = ACC_ADD;
      end
      3'd7: begin
        uw.acc_op  = ACC_ADD;
        uw.sec_end = 1'b1;
      end
      default: uw = UCODE_NOP;
    endcase
    return uw;
  endfunction

endpackage

`default_nettype wire

### src/ibc_in_if.sv
// ----------------------------------------------------------------------------
// ibc_in_if
// Input channel: sample or coefficient write, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ibc_in_if;
  logic              valid;
  logic              ready;
  logic              action;
  logic signed [15:0] sample;
  logic [3:0]        section;
  logic [2:0]        coef_index;
  logic signed [20:0] coef_value;

  modport source (output valid, action, sample, section, coef_index, coef_value,
                  input ready);
  modport sink   (input valid, action, sample, section, coef_index, coef_value,
                  output ready);
endinterface

`default_nettype wire

### src/ibc_out_if.sv
// ----------------------------------------------------------------------------
// ibc_out_if
// Output channel: filtered sample, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ibc_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] filtered;

  modport source (output valid, filtered, input ready);
  modport sink   (input valid, filtered, output ready);
endinterface

`default_nettype wire

### src/ibc_ram.sv
// ----------------------------------------------------------------------------
// ibc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ibc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### src/ibc_seq.sv
// ----------------------------------------------------------------------------
// ibc_seq
// Microcode sequencer: step counter, section counter and coefficient address.
// ----------------------------------------------------------------------------
`default_nettype none

module ibc_seq #(
  parameter int unsigned SECTIONS = ibc_pkg::SECTIONS_DEF,
  localparam int unsigned SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1,
  localparam int unsigned CAW   = $clog2(SECTIONS * ibc_pkg::COEFS_PER_SEC)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,     // sample transaction taken
  input  wire logic                 out_free_i,  // output register can load
  output      ibc_pkg::ctrl_t       ctrl_o,
  output      logic [SEC_W-1:0]     sec_o,
  output      logic [CAW-1:0]       rd_addr_o
);

  ibc_pkg::seq_state_e          state_q, state_d;
  logic [ibc_pkg::UPC_W-1:0]    upc_q, upc_d;
  logic [SEC_W-1:0]             sec_q, sec_d;
  logic [CAW-1:0]               base_q, base_d;
  ibc_pkg::ucode_t              uw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ibc_pkg::ST_IDLE;
      upc_q   <= '0;
      sec_q   <= '0;
      base_q  <= '0;
    end else begin
      state_q <= state_d;
      upc_q   <= upc_d;
      sec_q   <= sec_d;
      base_q  <= base_d;
    end
  end

  always_comb begin
    uw              = ibc_pkg::ucode(upc_q);
    state_d         = state_q;
    upc_d           = upc_q;
    sec_d           = sec_q;
    base_d          = base_q;
    ctrl_o.uw       = ibc_pkg::UCODE_NOP;
    ctrl_o.idle     = 1'b0;
    ctrl_o.load_out = 1'b0;
    unique case (state_q)
      ibc_pkg::ST_IDLE: begin
        ctrl_o.idle = 1'b1;
        if (start_i) begin
          state_d = ibc_pkg::ST_RUN;
          upc_d   = '0;
          sec_d   = '0;
          base_d  = '0;
        end
      end
      ibc_pkg::ST_RUN: begin
        ctrl_o.uw = uw;
        if (uw.sec_end) begin
          upc_d = '0;
          if (sec_q == SEC_W'(SECTIONS - 1)) begin
            state_d = ibc_pkg::ST_OUT;
          end else begin
            sec_d  = sec_q + 1'b1;
            base_d = base_q + CAW'(ibc_pkg::COEFS_PER_SEC);
          end
        end else begin
          upc_d = upc_q + 1'b1;
        end
      end
      ibc_pkg::ST_OUT: begin
        // hold the result in the accumulator until the output register frees
        ctrl_o.load_out = out_free_i;
        if (out_free_i) begin
          state_d = ibc_pkg::ST_IDLE;
        end
      end
      default: state_d = ibc_pkg::ST_IDLE;
    endcase
  end

  assign sec_o     = sec_q;
  assign rd_addr_o = base_q + CAW'(ctrl_o.uw.rd_k);

`include "assert_macros.svh"

  `IBC_ASSERT(a_sec_in_range, 32'(sec_q) < 32'(SECTIONS), "section counter out of range")
  `IBC_ASSERT(a_base_tracks_sec, (state_q == ibc_pkg::ST_RUN && upc_q == '0) |-> (32'(base_q) == 32'(sec_q) * ibc_pkg::COEFS_PER_SEC), "coefficient base out of step with section")

endmodule

`default_nettype wire

### src/iir_biquad_cascade_df2.sv
// Cascaded direct-form-II biquad IIR filter, 16-bit fixed-point audio.
//
// in_ch_i carries two kinds of transaction, told apart by action. A
// coefficient write (action 1) stores a Q11 value for one section and
// selector; writes to a section or selector beyond the filter are dropped.
// It gives no result and leaves the input ready. A sample (action 0) runs through
// all sections and gives one filtered sample on out_ch_o.
// A sample runs the eight-step microprogram once per section on one shared
// 21x21 multiplier and the coefficient RAM behind it, with its separate
// write and read ports; the result then moves to the output register, and
// the next transaction is taken once the sequencer is idle again.
// Reset clears the delay line and marks every coefficient as zero.
// When the receiver stalls, the result waits in the output register while
// coefficient writes and the next sample are still taken; a sample that
// finishes while the old result still waits holds in the output state.
// ----------------------------------------------------------------------------
// iir_biquad_cascade_df2
// Top level: handshake, coefficient store, delay line and MAC datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_biquad_cascade_df2 #(
  parameter int unsigned SECTIONS = ibc_pkg::SECTIONS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ibc_in_if.sink     in_ch_i,
  ibc_out_if.source  out_ch_o
);

  localparam int unsigned SEC_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int unsigned CDEPTH = SECTIONS * ibc_pkg::COEFS_PER_SEC;
  localparam int unsigned CAW    = $clog2(CDEPTH);
  localparam int unsigned W_W    = ibc_pkg::COEF_W;
  localparam int unsigned ACC_W  = ibc_pkg::ACC_W;
  localparam int unsigned FRAC   = ibc_pkg::FRAC_BITS;

  ibc_pkg::ctrl_t            ctrl;
  logic [SEC_W-1:0]          sec;
  logic [CAW-1:0]            rd_addr;

  logic                      in_take;
  logic                      sample_start;
  logic                      coef_we;
  logic [ibc_pkg::LIN_W-1:0] coef_lin;
  logic [CAW-1:0]            coef_waddr;

  logic [CDEPTH-1:0]         coef_vld_q;
  logic                      coef_rd_vld_q;
  logic [W_W-1:0]            coef_rdata;
  logic signed [W_W-1:0]     coef_op;
  logic signed [W_W-1:0]     data_op;
  logic signed [2*W_W-1:0]   prod_full;

  logic [W_W-1:0]            dly1_q [SECTIONS];
  logic [W_W-1:0]            dly2_q [SECTIONS];
  logic [W_W-1:0]            w1_q, w2_q;
  logic [ACC_W-1:0]          prod_q;
  logic [ACC_W-1:0]          acc_q, acc_d;
  logic [W_W-1:0]            w_cur;

  logic                      out_vld_q;
  logic [ibc_pkg::SAMPLE_W-1:0] filt_q;
  logic                      out_free;

  // --------------------------------------------------------------------------
  // Input handshake and coefficient write decode
  // --------------------------------------------------------------------------
  assign in_ch_i.ready = ctrl.idle;
  assign in_take       = in_ch_i.valid && ctrl.idle;
  assign sample_start  = in_take && (in_ch_i.action == ibc_pkg::ACTION_SAMPLE);

  // Row address: section*5 + selector, done as a shift and an add.
  assign coef_lin = ({4'b0, in_ch_i.section} << 2) + {4'b0, in_ch_i.section}
                  + {5'b0, in_ch_i.coef_index};
  assign coef_waddr = coef_lin[CAW-1:0];
  assign coef_we = in_take && (in_ch_i.action == ibc_pkg::ACTION_COEF)
                && (32'(in_ch_i.section) < 32'(SECTIONS))
                && (32'(in_ch_i.coef_index) < 32'(ibc_pkg::COEFS_PER_SEC));

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign out_free = !out_vld_q || out_ch_o.ready;

  ibc_seq #(
    .SECTIONS (SECTIONS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sample_start),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .sec_o      (sec),
    .rd_addr_o  (rd_addr)
  );

  // --------------------------------------------------------------------------
  // Coefficient store: RAM plus a written flag per entry, so that an entry
  // never written since reset reads as zero.
  // --------------------------------------------------------------------------
  ibc_ram #(
    .WIDTH (W_W),
    .DEPTH (CDEPTH)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (in_ch_i.coef_value),
    .re_i    (ctrl.uw.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (coef_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q    <= '0;
      coef_rd_vld_q <= 1'b0;
    end else begin
      if (coef_we) begin
        coef_vld_q[coef_waddr] <= 1'b1;
      end
      if (ctrl.uw.rd_en) begin
        coef_rd_vld_q <= coef_vld_q[rd_addr];
      end
    end
  end

  assign coef_op = coef_rd_vld_q ? coef_rdata : '0;

  // --------------------------------------------------------------------------
  // Multiplier: coefficient times w1, w2 or the fresh w, wrapped to 32 bits
  // --------------------------------------------------------------------------
  assign w_cur = acc_q[ACC_W-1:FRAC];

  always_comb begin
    case (ctrl.uw.mul_sel)
      ibc_pkg::MUL_W1: data_op = w1_q;
      ibc_pkg::MUL_W2: data_op = w2_q;
      ibc_pkg::MUL_W:  data_op = w_cur;
      default:         data_op = w1_q;
    endcase
  end

  assign prod_full = coef_op * data_op;

  always_ff @(posedge clk_i) begin
    if (ctrl.uw.mul_en) begin
      prod_q <= prod_full[ACC_W-1:0];
    end
    if (ctrl.uw.latch_w) begin
      w1_q <= dly1_q[sec];
      w2_q <= dly2_q[sec];
    end
  end

  // --------------------------------------------------------------------------
  // Accumulator: holds x between sections, w's sum, then y
  // --------------------------------------------------------------------------
  always_comb begin
    acc_d = acc_q;
    if (sample_start) begin
      // sign-extend the sample and scale it by 2^11
      acc_d = {{(ACC_W - ibc_pkg::SAMPLE_W - FRAC){in_ch_i.sample[ibc_pkg::SAMPLE_W-1]}},
               in_ch_i.sample, {FRAC{1'b0}}};
    end else begin
      case (ctrl.uw.acc_op)
        ibc_pkg::ACC_SUB:  acc_d = acc_q - prod_q;
        ibc_pkg::ACC_LOAD: acc_d = prod_q;
        ibc_pkg::ACC_ADD:  acc_d = acc_q + prod_q;
        default:           acc_d = acc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // --------------------------------------------------------------------------
  // Delay line: advance the section's w2 <= w1, w1 <= w
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(SECTIONS); i++) begin
        dly1_q[i] <= '0;
        dly2_q[i] <= '0;
      end
    end else if (ctrl.uw.wr_delay) begin
      dly1_q[sec] <= w_cur;
      dly2_q[sec] <= w1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctrl.load_out) begin
      out_vld_q <= 1'b1;
    end else if (out_ch_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load_out) begin
      filt_q <= acc_q[FRAC + ibc_pkg::SAMPLE_W - 1:FRAC];
    end
  end

  assign out_ch_o.valid    = out_vld_q;
  assign out_ch_o.filtered = filt_q;

`include "assert_macros.svh"

  `IBC_ASSERT(a_wr_sets_flag, coef_we |=> coef_vld_q[$past(coef_waddr)], "written coefficient not flagged")
  `IBC_ASSERT(a_busy_after_start, sample_start |=> !ctrl.idle, "sequencer idle after sample transaction")
  `IBC_ASSERT_NEVER(a_no_overwrite, ctrl.load_out && out_vld_q && !out_ch_o.ready, "result loaded over a waiting result")

endmodule

`default_nettype wire

### test/iir_biquad_cascade_df2_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_biquad_cascade_df2_checker
// Watches both channels of the biquad cascade and predicts every filtered
// sample from its own copy of the coefficients and delay line. Each
// transaction on out_ch is compared with the oldest predicted sample.
// ----------------------------------------------------------------------------

module iir_biquad_cascade_df2_checker
  import ibc_pkg::*;
#(
  parameter int unsigned SECTIONS = SECTIONS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ibc_in_if           in_ch,
  ibc_out_if          out_ch,
  output int unsigned mismatches_o,
  output int unsigned outstanding_o,
  output int unsigned samples_o,
  output int unsigned coef_writes_o,
  output int unsigned dropped_writes_o,
  output int unsigned results_o
);

  logic signed [20:0] w_one [SECTIONS];
  logic signed [20:0] w_two [SECTIONS];
  logic signed [20:0] coefs [SECTIONS*COEFS_PER_SEC];
  logic signed [15:0] pending_outputs [$];
  logic signed [15:0] want;
  int unsigned        mismatch_cnt, sample_cnt, write_cnt, drop_cnt, result_cnt;

  // Push one sample through all sections, advancing the delay line.
  function automatic logic signed [15:0] run_cascade(input logic signed [15:0] smp);
    logic signed [31:0] x, acc, w, w1, w2, b0, b1, b2, a1, a2;
    int                 s;
    x = smp;
    x = x << FRAC_BITS;
    for (s = 0; s < SECTIONS; s++) begin
      w1  = w_one[s];
      w2  = w_two[s];
      b0  = coefs[s*COEFS_PER_SEC + K_B0];
      b1  = coefs[s*COEFS_PER_SEC + K_B1];
      b2  = coefs[s*COEFS_PER_SEC + K_B2];
      a1  = coefs[s*COEFS_PER_SEC + K_A1];
      a2  = coefs[s*COEFS_PER_SEC + K_A2];
      acc = x - a1 * w1 - a2 * w2;
      w   = acc >>> FRAC_BITS;
      x   = b0 * w + b1 * w1 + b2 * w2;
      w_two[s] = w_one[s];
      w_one[s] = w[20:0];
    end
    return x[FRAC_BITS +: 16];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SECTIONS; i++) begin
        w_one[i] = '0;
        w_two[i] = '0;
      end
      for (int i = 0; i < SECTIONS*COEFS_PER_SEC; i++) coefs[i] = '0;
      pending_outputs.delete();
      mismatch_cnt = 0;
      sample_cnt   = 0;
      write_cnt    = 0;
      drop_cnt     = 0;
      result_cnt   = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.action == ACTION_COEF) begin
          write_cnt++;
          if (in_ch.section < SECTIONS && in_ch.coef_index < COEFS_PER_SEC)
            coefs[in_ch.section*COEFS_PER_SEC + in_ch.coef_index] = in_ch.coef_value;
          else
            drop_cnt++;
        end else begin
          sample_cnt++;
          pending_outputs.push_back(run_cascade(in_ch.sample));
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        result_cnt++;
        if (pending_outputs.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("[%0t] unexpected filtered sample %0d", $time, out_ch.filtered);
          mismatch_cnt++;
        end else begin
          want = pending_outputs.pop_front();
          if (out_ch.filtered !== want) begin
            if (mismatch_cnt < 10)
              $display("[%0t] filtered sample %0d: expected %0d, got %0d",
                       $time, result_cnt, want, out_ch.filtered);
            mismatch_cnt++;
          end
        end
      end
    end
    mismatches_o     <= mismatch_cnt;
    outstanding_o    <= pending_outputs.size();
    samples_o        <= sample_cnt;
    coef_writes_o    <= write_cnt;
    dropped_writes_o <= drop_cnt;
    results_o        <= result_cnt;
  end

endmodule

### test/iir_biquad_cascade_df2_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_biquad_cascade_df2_test
// Stimulus for the biquad cascade: a directed opening that covers zero
// coefficients, unity gain, extreme values and dropped writes, then random
// section loads and sample bursts under four idling mixes, one long output
// hold-off and one drain pause. The checker does all comparing.
// ----------------------------------------------------------------------------

module iir_biquad_cascade_df2_test;
  import ibc_pkg::*;

  localparam int unsigned SECTIONS       = SECTIONS_DEF;
  localparam int unsigned RANDOM_ITEMS   = 1600;
  localparam int unsigned HOLDOFF_CYCLES = 800;
  // The quiet limit covers the long hold-off plus a full sample many
  // times over.
  localparam int unsigned QUIET_LIMIT    = 5000;
  localparam int unsigned TAIL_CYCLES    = 8*SECTIONS + 30;

  // Writes the block must drop.
  localparam logic [3:0] SEC_PAST_END = 4'(SECTIONS);
  localparam logic [3:0] SEC_TOP      = 4'd15;
  localparam logic [2:0] K_PAST_END   = 3'd5;
  localparam logic [2:0] K_TOP        = 3'd7;

  localparam logic signed [20:0] COEF_MIN = -21'sd1048576;
  localparam logic signed [20:0] COEF_MAX = 21'sd1048575;
  localparam logic signed [20:0] Q11_ONE  = 21'sd2048;

  localparam logic signed [15:0] SAMPLE_MIN = -16'sd32768;
  localparam logic signed [15:0] SAMPLE_MAX = 16'sd32767;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ibc_in_if  in_ch ();
  ibc_out_if out_ch ();

  int unsigned mismatches, outstanding, samples, coef_writes, dropped_writes, results;

  int unsigned idle_pct;         // sender, used by the main process only
  int unsigned stall_pct;        // receiver, written with NBAs
  int unsigned holdoffs_asked;   // bumped by the main process
  int unsigned holdoffs_served;  // owned by the receiver
  int unsigned items_counted;    // accepted transactions the block acts on
  int unsigned quiet_cycles;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  iir_biquad_cascade_df2 #(
    .SECTIONS (SECTIONS)
  ) DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch)
  );

  iir_biquad_cascade_df2_checker #(
    .SECTIONS (SECTIONS)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_ch            (in_ch),
    .out_ch           (out_ch),
    .mismatches_o     (mismatches),
    .outstanding_o    (outstanding),
    .samples_o        (samples),
    .coef_writes_o    (coef_writes),
    .dropped_writes_o (dropped_writes),
    .results_o        (results)
  );

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off whenever one is asked for.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned hold_left;
    hold_left       = 0;
    holdoffs_served = 0;
    out_ch.ready   <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        // Hold ready low; the block fills up and must stall its input.
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (holdoffs_asked != holdoffs_served) begin
        out_ch.ready <= 1'b0;
        hold_left = HOLDOFF_CYCLES - 1;
        holdoffs_served++;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no transaction moves for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[%0t] no transaction for %0d cycles, %0d results still pending",
               $time, QUIET_LIMIT, outstanding);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sender helpers
  // --------------------------------------------------------------------------

  // Offer one transaction after a random idle gap and wait until it is
  // taken. Valid stays high on return so back-to-back items need no gap.
  task automatic offer(input logic act, input logic signed [15:0] smp,
                       input logic [3:0] sec, input logic [2:0] idx,
                       input logic signed [20:0] val);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.sample     <= smp;
    in_ch.section    <= sec;
    in_ch.coef_index <= idx;
    in_ch.coef_value <= val;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Unused coefficient fields carry noise; the block must ignore them.
  task automatic offer_sample(input logic signed [15:0] smp);
    offer(ACTION_SAMPLE, smp, 4'($urandom), 3'($urandom), 21'($urandom));
    items_counted++;
  endtask

  task automatic offer_coef(input logic [3:0] sec, input logic [2:0] idx,
                            input logic signed [20:0] val);
    offer(ACTION_COEF, 16'($urandom), sec, idx, val);
    if (sec < SECTIONS && idx < COEFS_PER_SEC) items_counted++;
  endtask

  // Drop valid and wait until every predicted sample has come out. The
  // checker's count is registered, so always wait for an edge before the first look.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  function automatic logic signed [20:0] pick_coef();
    logic signed [20:0] val;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: val = 21'(int'($urandom_range(0, 8191)) - 4096);  // near unity
      4, 5, 6, 7: val = 21'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0:       val = COEF_MIN;
          1:       val = COEF_MAX;
          2:       val = Q11_ONE;
          3:       val = -21'sd1;
          default: val = '0;
        endcase
      end
    endcase
    return val;
  endfunction

  function automatic logic signed [15:0] pick_sample();
    logic signed [15:0] smp;
    case ($urandom_range(0, 9))
      0, 1: smp = 16'(int'($urandom_range(0, 511)) - 256);
      2, 3: begin
        case ($urandom_range(0, 4))
          0:       smp = SAMPLE_MIN;
          1:       smp = SAMPLE_MAX;
          2:       smp = 16'sd1;
          3:       smp = -16'sd1;
          default: smp = '0;
        endcase
      end
      default: smp = 16'($urandom);
    endcase
    return smp;
  endfunction

  // One random episode: mostly full section loads and sample bursts, now
  // and then a lone write or a write the block has to drop.
  task automatic random_episode();
    int unsigned pick, n, sec, k;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      sec = $urandom_range(0, SECTIONS - 1);
      for (k = 0; k < COEFS_PER_SEC; k++) offer_coef(4'(sec), 3'(k), pick_coef());
    end else if (pick < 88) begin
      n = $urandom_range(1, 8);
      repeat (n) offer_sample(pick_sample());
    end else if (pick < 93) begin
      offer_coef(4'($urandom_range(0, SECTIONS - 1)), 3'($urandom_range(0, 4)), pick_coef());
    end else if (pick < 97) begin
      offer_coef(4'($urandom_range(SECTIONS, 15)), 3'($urandom), 21'($urandom));
    end else begin
      offer_coef(4'($urandom_range(0, 15)), 3'($urandom_range(5, 7)), 21'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int          ph, s;
    int unsigned phase_goal;
    bit          paused;

    idle_pct       = 0;
    items_counted  = 0;
    paused         = 1'b0;
    stall_pct      <= 0;
    holdoffs_asked <= 0;
    in_ch.valid      <= 1'b0;
    in_ch.action     <= ACTION_SAMPLE;
    in_ch.sample     <= '0;
    in_ch.section    <= '0;
    in_ch.coef_index <= '0;
    in_ch.coef_value <= '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening. Cleared coefficients must give silence.
    offer_sample(SAMPLE_MAX);
    // Unity gain through every section, then full-scale samples.
    for (s = 0; s < SECTIONS; s++) offer_coef(4'(s), K_B0, Q11_ONE);
    offer_sample(SAMPLE_MIN);
    offer_sample(SAMPLE_MAX);
    // Extreme coefficients at the first, middle and last sections and at section 3.
    offer_coef(4'(SECTIONS - 1), K_A1, COEF_MIN);
    offer_coef(4'd0, K_A2, COEF_MAX);
    offer_coef(4'(SECTIONS / 2), K_B1, COEF_MAX);
    offer_coef(4'd3, K_B2, COEF_MIN);
    // Writes past the last section or selector must not land anywhere.
    offer_coef(SEC_PAST_END, K_B0, '0);
    offer_coef(SEC_TOP, K_TOP, '0);
    offer_coef(4'd0, K_PAST_END, '0);
    offer_coef(4'(SECTIONS - 1), K_TOP, '0);
    offer_sample(SAMPLE_MAX);
    offer_sample(SAMPLE_MIN);
    offer_sample(16'sd1);

    // Random part in four idling mixes.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
          // Ask for one long output hold-off while items keep coming.
          holdoffs_asked <= holdoffs_asked + 1;
        end
        1: begin
          idle_pct = 86;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 86;
        end
        default: begin
          idle_pct = 13;
          stall_pct <= 13;
        end
      endcase
      phase_goal = items_counted + RANDOM_ITEMS / 4;
      while (items_counted < phase_goal) begin
        random_episode();
        // Halfway through the stalled phase, pause until all is out.
        if (ph == 2 && !paused && items_counted + RANDOM_ITEMS / 8 >= phase_goal) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d samples and %0d coefficient writes (%0d dropped), %0d results",
             samples, coef_writes, dropped_writes, results);
    $display("idling: none, sender 86%%, receiver 86%%, both 13%%; one hold-off, one drain");
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
